// ----- sv/mmcs_pkg.sv -----
// Shared types and constants for the min-max contrast stretch core.
// Used by mmcs_state_mem, mmcs_divider and minmax_contrast_stretch_core.
package mmcs_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned DvdW  = 2 * PixW + 1;
  localparam int unsigned DivW  = PixW + 1;

  localparam logic [PixW-1:0] FullScale = 8'd255;
  localparam logic [PixW-1:0] LowReset  = 8'd255;
  localparam logic [PixW-1:0] HighReset = 8'd0;

  // Operation codes of an input beat
  localparam logic OpScan = 1'b0;
  localparam logic OpMap  = 1'b1;

  typedef struct packed {
    logic            operation;
    logic            first;
    logic [PixW-1:0] pixel;
  } in_t;

  typedef struct packed {
    logic [PixW-1:0] stretched;
    logic            range_ok;
  } out_t;

  // One word of the tracking memory: running minimum and maximum
  typedef struct packed {
    logic [PixW-1:0] low;
    logic [PixW-1:0] high;
  } track_t;

  typedef struct packed {
    logic   rd_en;
    logic   wr_en;
    track_t wdata;
  } mem_req_t;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

endpackage

// ----- sv/mmcs_state_mem.sv -----
// Tracking memory of the contrast stretch core: one word holding min and max.
// Synchronous read: the read data is registered and appears in the cycle after rd_en; depends on mmcs_pkg.
module mmcs_state_mem
  import mmcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output track_t   rdata_o
);

  track_t mem_q;
  track_t rdata_q;
  logic   valid_q;

  // Track whether the word was ever written; unwritten reads give reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.wr_en) begin
      valid_q <= 1'b1;
    end
  end

  // Write the storage word
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q <= req_i.wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      if (valid_q) begin
        rdata_q <= mem_q;
      end else begin
        rdata_q <= '{low: LowReset, high: HighReset};
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mmcs_divider.sv -----
// Restoring divider, one quotient bit per cycle, eight-bit quotient.
// Depends on mmcs_pkg; the caller guarantees the quotient fits in eight bits.
module mmcs_divider
  import mmcs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [PixW-1:0] quotient_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [PixW-1:0] dvd_q, dvd_d;
  logic [DivW-1:0] div_q, div_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            qbit;

  // Shift one dividend bit into the remainder and try the subtract
  always_comb begin
    trial = {rem_q, dvd_q[PixW-1]};
    diff  = trial - {1'b0, div_q};
    qbit  = (trial >= {1'b0, div_q});
  end

  // Advance the iteration
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[DvdW-1:PixW];
      dvd_d  = req_i.dividend[PixW-1:0];
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = qbit ? diff[DivW-1:0] : trial[DivW-1:0];
      dvd_d = {dvd_q[PixW-2:0], qbit};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

`ifndef NO_ASSERTIONS
  // A new division never starts on top of a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // Completion follows the last iteration only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(cnt_q) == 3'd7)
    else $error("divider done without a final step");
`endif

endmodule

// ----- sv/minmax_contrast_stretch_core.sv -----
// Min-max contrast stretch core: scan beats fold a pixel into min/max, a first scan beat
// restarting both; map beats return (pixel-min)*255/(max-min) rounded half up, with the
// pixel clamped to min..max, or the pixel when max is not above min. Throughput: one beat
// at a time; set by the memory read-modify-write, the one-bit-per-cycle divider
// (8 iterations) and output stalls. Reset is asynchronous, active low, and leaves
// min = 255, max = 0, so maps pass pixels through until scans widen the range.
module minmax_contrast_stretch_core
  import mmcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_HOLD = 5'b10000
  } state_e;

  state_e   state_q, state_d;
  in_t      item_q;
  out_t     pend_q, pend_d;
  out_t     out_q, out_d;
  logic     out_valid_q, out_valid_d;
  mem_req_t mem_req;
  track_t   rd_data;
  div_req_t div_req;
  logic            div_done;
  logic [PixW-1:0] quotient;
  logic            in_accept;

  logic              range_ok;
  logic [PixW-1:0]   px_clamp;
  logic [PixW-1:0]   diff;
  logic [PixW-1:0]   den;
  logic [2*PixW-1:0] num;

  mmcs_state_mem u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rdata_o(rd_data)
  );

  mmcs_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Clamp the pixel into the tracked range and form numerator and range
  always_comb begin
    range_ok = rd_data.high > rd_data.low;
    px_clamp = item_q.pixel;
    if (px_clamp < rd_data.low) begin
      px_clamp = rd_data.low;
    end
    if (px_clamp > rd_data.high) begin
      px_clamp = rd_data.high;
    end
    diff = px_clamp - rd_data.low;
    den  = rd_data.high - rd_data.low;
    num  = {8'd0, diff} * {8'd0, FullScale};
  end

  // Sequence read, modify and write back, and the division and output steps of map beats
  always_comb begin
    state_d          = state_q;
    pend_d           = pend_q;
    mem_req          = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {num, 1'b0} + {{(DvdW-PixW){1'b0}}, den};
    div_req.divisor  = {den, 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mem_req.rd_en = 1'b1;
          state_d       = ST_CALC;
        end
      end
      ST_CALC: begin
        if (item_q.operation == OpScan) begin
          mem_req.wr_en = 1'b1;
          if (item_q.first) begin
            mem_req.wdata = '{low: item_q.pixel, high: item_q.pixel};
          end else begin
            mem_req.wdata = rd_data;
            if (item_q.pixel < rd_data.low) begin
              mem_req.wdata.low = item_q.pixel;
            end
            if (item_q.pixel > rd_data.high) begin
              mem_req.wdata.high = item_q.pixel;
            end
          end
          state_d = ST_IDLE;
        end else if (range_ok) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else begin
          pend_d  = '{stretched: item_q.pixel, range_ok: 1'b0};
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          pend_d  = '{stretched: quotient, range_ok: 1'b1};
          state_d = ST_OUT;
        end
      end
      ST_OUT, ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Load the output register when the pending result may go out
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_OUT || state_q == ST_HOLD) && (!out_valid_q || out_ready_i)) begin
      out_d       = pend_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the accepted beat and the payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // Write back only from the modify step of a scan beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.wr_en |-> state_q == ST_CALC && item_q.operation == OpScan)
    else $error("tracking memory written outside a scan update");

  // A finished division always moves its result toward the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_done) |=> state_q == ST_OUT)
    else $error("division result dropped");
`endif

endmodule

// ----- tb/tb_minmax_contrast_stretch_core.sv -----
// Self-checking testbench for minmax_contrast_stretch_core: directed table, then random
// scan/map sets under varying idle and stall patterns, checked by an in-bench predictor.
// Depends on mmcs_pkg (in_t, out_t, OpScan, OpMap) and the core RTL.
module tb_minmax_contrast_stretch_core;
  import mmcs_pkg::*;

  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t want;
  } dir_row_t;

  localparam int unsigned DirRows  = 25;
  localparam int unsigned HoldLen  = 400;
  localparam int unsigned TailWait = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Running min/max as the block should hold them
  logic [PixW-1:0] track_low  = LowReset;
  logic [PixW-1:0] track_high = HighReset;
  out_t            stretch_due [$];

  int unsigned mismatches   = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned hold_asks    = 0;
  int unsigned hold_granted = 0;
  int unsigned hold_left    = 0;

  // Directed rows; typed expectations only where obvious, the rest predicted
  dir_row_t dir_rows [DirRows] = '{
    '{'{OpMap,  1'b1, 8'hA5}, 1'b1, '{8'hA5, 1'b0}},
    '{'{OpMap,  1'b0, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'hFF}, 1'b1, '{8'hFF, 1'b0}},
    '{'{OpScan, 1'b0, 8'h64}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'h64}, 1'b1, '{8'h64, 1'b0}},
    '{'{OpScan, 1'b1, 8'h0A}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'hC8}, 1'b1, '{8'hC8, 1'b0}},
    '{'{OpScan, 1'b0, 8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpScan, 1'b0, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{OpMap,  1'b0, 8'hFF}, 1'b1, '{8'hFF, 1'b1}},
    '{'{OpMap,  1'b0, 8'h80}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpScan, 1'b1, 8'h32}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpScan, 1'b0, 8'h3C}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'h28}, 1'b1, '{8'h00, 1'b1}},
    '{'{OpMap,  1'b1, 8'h46}, 1'b1, '{8'hFF, 1'b1}},
    '{'{OpMap,  1'b0, 8'h37}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'h33}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpScan, 1'b1, 8'hFE}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpScan, 1'b0, 8'hFF}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'hFE}, 1'b1, '{8'h00, 1'b1}},
    '{'{OpMap,  1'b0, 8'h00}, 1'b1, '{8'h00, 1'b1}},
    '{'{OpScan, 1'b1, 8'h00}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpScan, 1'b0, 8'h01}, 1'b0, '{8'h00, 1'b0}},
    '{'{OpMap,  1'b0, 8'h01}, 1'b1, '{8'hFF, 1'b1}}
  };

  minmax_contrast_stretch_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Fold a scan beat into min/max, or work out the stretched value of a map beat
  function automatic void track_and_stretch(input in_t b, output bit gives, output out_t res);
    int unsigned px, num, den;
    gives = 1'b0;
    res   = '0;
    if (b.operation == OpScan) begin
      if (b.first) begin
        track_low  = b.pixel;
        track_high = b.pixel;
      end else begin
        if (b.pixel < track_low) track_low = b.pixel;
        if (b.pixel > track_high) track_high = b.pixel;
      end
    end else begin
      gives = 1'b1;
      if (track_high > track_low) begin
        px = 32'(b.pixel);
        if (px < 32'(track_low)) px = 32'(track_low);
        if (px > 32'(track_high)) px = 32'(track_high);
        num = (px - 32'(track_low)) * 255;
        den = 32'(track_high) - 32'(track_low);
        res.stretched = PixW'((2 * num + den) / (2 * den));
        res.range_ok  = 1'b1;
      end else begin
        res.stretched = b.pixel;
        res.range_ok  = 1'b0;
      end
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  // Offer one beat after a random gap and hold it until accepted
  task automatic offer_beat(input in_t b, input bit typed, input out_t want);
    int unsigned gap;
    bit          gives;
    out_t        res;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_and_stretch(b, gives, res);
    if (gives) stretch_due = {stretch_due, (typed ? want : res)};
  endtask

  task automatic send_pixel(input logic op, input logic first, input int unsigned px);
    in_t b;
    b.operation = op;
    b.first     = first;
    b.pixel     = PixW'(px);
    offer_beat(b, 1'b0, '0);
  endtask

  // Mostly well-formed image sets (scan with first, more scans, then maps), some noise
  task automatic run_random(input int unsigned beats);
    int unsigned sent, lo, hi, n_scan, n_map;
    in_t         junk;
    sent = 0;
    while (sent < beats) begin
      if ($urandom_range(9) < 8) begin
        lo = $urandom_range(255);
        case ($urandom_range(3))
          0: hi = lo;
          1: hi = (lo + $urandom_range(1, 8) > 255) ? 255 : lo + $urandom_range(1, 8);
          2: hi = $urandom_range(lo, 255);
          default: begin
            lo = $urandom_range(3);
            hi = $urandom_range(252, 255);
          end
        endcase
        n_scan = $urandom_range(1, 12);
        for (int i = 0; i < n_scan; i++)
          send_pixel(OpScan, i == 0, $urandom_range(lo, hi));
        n_map = $urandom_range(1, 16);
        for (int i = 0; i < n_map; i++) begin
          if ($urandom_range(3) == 0)
            send_pixel(OpMap, 1'($urandom_range(1)), $urandom_range(255));
          else
            send_pixel(OpMap, 1'($urandom_range(1)), $urandom_range(lo, hi));
        end
        sent += n_scan + n_map;
      end else begin
        repeat (8) begin
          junk.operation = 1'($urandom_range(1));
          junk.first     = 1'($urandom_range(1));
          junk.pixel     = PixW'($urandom_range(255));
          offer_beat(junk, 1'b0, '0);
        end
        sent += 8;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_granted != hold_asks) begin
        hold_granted++;
        hold_left = HoldLen - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stretch_due.size() == 0) begin
        note_mismatch($sformatf("unexpected beat stretched=%0d range_ok=%0b",
                                out_data_o.stretched, out_data_o.range_ok));
      end else begin
        want = stretch_due.pop_front();
        if (out_data_o.stretched !== want.stretched)
          note_mismatch($sformatf("stretched expected %0d got %0d",
                                  want.stretched, out_data_o.stretched));
        if (out_data_o.range_ok !== want.range_ok)
          note_mismatch($sformatf("range_ok expected %0b got %0b",
                                  want.range_ok, out_data_o.range_ok));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 32;
    rx_idle_pct = 57;
    for (int i = 0; i < DirRows; i++)
      offer_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    run_random(475);

    tx_idle_pct = 57;
    rx_idle_pct = 32;
    run_random(500);

    // No idling; stall the receiver long enough to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asks++;
    run_random(500);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (stretch_due.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (stretch_due.size() != 0) note_mismatch("results still expected at end");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
